// ===== hdl/brk4_pkg.sv =====
// Package for the Blasius RK4 stepper: widths, constants, sequencer codes and fixed-point helpers.
package brk4_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int STEP_W     = 25;
    localparam int MAX_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OVF_W      = PROD_W - FRAC_W - DATA_W + 1;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_word WORD_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_word WORD_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_word CURVE_RESET = DATA_W'(64'd1 << FRAC_W);
    localparam t_word SIXTH       = DATA_W'(((64'd1 << FRAC_W) + 64'd3) / 64'd6);
    localparam t_word NEG_HALF    = DATA_W'(-(64'sd1 <<< (FRAC_W - 1)));

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(167772);
    localparam logic [MAX_W-1:0]  MAX_RESET  = MAX_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CURVE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_COEF,
        OP_P,
        OP_K,
        OP_T0,
        OP_T1,
        OP_T2,
        OP_Y0,
        OP_Y1,
        OP_Y2
    } t_op;

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? WORD_MIN : WORD_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // Taking the upper bits of the product is a floor shift; saturate if the
    // bits above the kept word are not a plain sign extension.
    function automatic t_word mul_scale(input t_prod p);
        logic [OVF_W-1:0] top;
        top = p[PROD_W-1:FRAC_W+DATA_W-1];
        if (top != '0 && top != '1) begin
            return p[PROD_W-1] ? WORD_MIN : WORD_MAX;
        end
        return p[FRAC_W+DATA_W-1:FRAC_W];
    endfunction

endpackage

// ===== hdl/blasius_rk4_stepper_top.sv =====
// Top level of the Blasius RK4 stepper: sequencer around one shared multiplier.
//
// Usage: each input word carries i_restart. A restart loads f = 0, f' = 0,
// f'' = initial curvature, eta = 0 and returns that point. An advance takes
// one classic RK4 step of size step_size and returns eta, f, f', f''; once
// the step count reaches max_steps an advance returns the held point with
// o_done_res set. Every input word gives exactly one output word.
// Input channel: i_in_valid / o_in_stall; a word is taken when valid is high
// and stall is low. o_in_stall is high while an item is in work.
// Output channel: o_out_valid / i_out_stall, held in an output register.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is
// step_size, 1 initial_curvature, 2 max_steps; write only while idle.
// Sequence: an advance runs 21 products through the one 32x32 multiplier,
// each as a multiply state, then a scale/saturate/add writeback state, with
// a stage accumulation state after each RK stage; the result is then registered.
// Restart and held advances go straight to the output state. No new word is
// taken until the current result is registered and the sequencer is idle.
// Reset (synchronous, active low) loads the default registers and the
// starting point with f'' = 1.0. A stalled receiver holds the result; the
// sequencer then waits in its output state until the register is free.
module blasius_rk4_stepper_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_restart,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [brk4_pkg::DATA_W-1:0]       o_eta_pos,
    output logic signed [brk4_pkg::DATA_W-1:0]       o_f_value,
    output logic signed [brk4_pkg::DATA_W-1:0]       o_f_slope,
    output logic signed [brk4_pkg::DATA_W-1:0]       o_f_curve,
    output logic                                     o_done_res,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [brk4_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [brk4_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import brk4_pkg::*;

    // Configuration registers.
    logic [STEP_W-1:0] r_step_size;
    t_word             r_init_curve;
    logic [MAX_W-1:0]  r_max_steps;

    // Sequencer.
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [1:0] r_stage, n_stage;

    // Solution state.
    t_word r_y0, n_y0, r_y1, n_y1, r_y2, n_y2, r_eta, n_eta;
    logic [MAX_W-1:0] r_count, n_count;

    // Working values.
    t_word r_t0, n_t0, r_t1, n_t1, r_t2, n_t2;
    t_word r_acc0, n_acc0, r_acc1, n_acc1, r_acc2, n_acc2;
    t_word r_p, n_p, r_kq, n_kq, r_coef, n_coef;
    t_prod r_prod, n_prod;

    // Output register.
    logic  r_out_valid, n_out_valid;
    t_word r_o_eta, n_o_eta, r_o_f, n_o_f, r_o_slope, n_o_slope, r_o_curve, n_o_curve;
    logic  r_o_done, n_o_done;

    t_word h, hh, w, mul_a, mul_b, q;
    t_word acc_in0, acc_in1, acc_in2;
    t_prod prod_full;
    logic  dbl_sel, first_stage;

    assign h  = t_word'({{(DATA_W-STEP_W){1'b0}}, r_step_size});
    assign hh = h >>> 1;
    // The first two trial points use h/2, the third uses h.
    assign w  = (r_stage == 2'd2) ? h : hh;

    always_comb begin
        case (r_op)
            OP_COEF: begin mul_a = SIXTH;    mul_b = h;      end
            OP_P:    begin mul_a = NEG_HALF; mul_b = r_t0;   end
            OP_K:    begin mul_a = r_p;      mul_b = r_t2;   end
            OP_T0:   begin mul_a = w;        mul_b = r_t1;   end
            OP_T1:   begin mul_a = w;        mul_b = r_t2;   end
            OP_T2:   begin mul_a = w;        mul_b = r_kq;   end
            OP_Y0:   begin mul_a = r_coef;   mul_b = r_acc0; end
            OP_Y1:   begin mul_a = r_coef;   mul_b = r_acc1; end
            OP_Y2:   begin mul_a = r_coef;   mul_b = r_acc2; end
            default: begin mul_a = SIXTH;    mul_b = h;      end
        endcase
    end

    assign prod_full = t_prod'(mul_a) * t_prod'(mul_b);
    assign q         = mul_scale(r_prod);

    // Middle stages carry weight two in the final sum.
    assign dbl_sel     = (r_stage == 2'd1) || (r_stage == 2'd2);
    assign first_stage = (r_stage == 2'd0);
    assign acc_in0     = dbl_sel ? sat_add(r_t1, r_t1) : r_t1;
    assign acc_in1     = dbl_sel ? sat_add(r_t2, r_t2) : r_t2;
    assign acc_in2     = dbl_sel ? sat_add(r_kq, r_kq) : r_kq;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_stage     = r_stage;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_y2        = r_y2;
        n_eta       = r_eta;
        n_count     = r_count;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_acc0      = r_acc0;
        n_acc1      = r_acc1;
        n_acc2      = r_acc2;
        n_p         = r_p;
        n_kq        = r_kq;
        n_coef      = r_coef;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_o_eta     = r_o_eta;
        n_o_f       = r_o_f;
        n_o_slope   = r_o_slope;
        n_o_curve   = r_o_curve;
        n_o_done    = r_o_done;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_restart) begin
                        n_y0    = '0;
                        n_y1    = '0;
                        n_y2    = r_init_curve;
                        n_eta   = '0;
                        n_count = '0;
                        n_state = ST_OUT;
                    end else if (r_count < r_max_steps) begin
                        // The first derivative is taken at the current point.
                        n_t0    = r_y0;
                        n_t1    = r_y1;
                        n_t2    = r_y2;
                        n_op    = OP_COEF;
                        n_stage = 2'd0;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = prod_full;
                n_state = ST_WB;
            end
            ST_WB: begin
                n_state = ST_MUL;
                case (r_op)
                    OP_COEF: begin n_coef = q; n_op = OP_P; end
                    OP_P:    begin n_p = q;    n_op = OP_K; end
                    OP_K:    begin n_kq = q;   n_state = ST_ACC; end
                    OP_T0:   begin n_t0 = sat_add(r_y0, q); n_op = OP_T1; end
                    OP_T1:   begin n_t1 = sat_add(r_y1, q); n_op = OP_T2; end
                    OP_T2: begin
                        n_t2    = sat_add(r_y2, q);
                        n_stage = r_stage + 2'd1;
                        n_op    = OP_P;
                    end
                    OP_Y0:   begin n_y0 = sat_add(r_y0, q); n_op = OP_Y1; end
                    OP_Y1:   begin n_y1 = sat_add(r_y1, q); n_op = OP_Y2; end
                    OP_Y2: begin
                        n_y2    = sat_add(r_y2, q);
                        n_eta   = sat_add(r_eta, h);
                        n_count = r_count + MAX_W'(1);
                        n_state = ST_OUT;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_ACC: begin
                n_acc0  = sat_add(first_stage ? t_word'(0) : r_acc0, acc_in0);
                n_acc1  = sat_add(first_stage ? t_word'(0) : r_acc1, acc_in1);
                n_acc2  = sat_add(first_stage ? t_word'(0) : r_acc2, acc_in2);
                n_op    = (r_stage == 2'd3) ? OP_Y0 : OP_T0;
                n_state = ST_MUL;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_o_eta     = r_eta;
                    n_o_f       = r_y0;
                    n_o_slope   = r_y1;
                    n_o_curve   = r_y2;
                    n_o_done    = (r_count >= r_max_steps);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_COEF;
            r_stage     <= 2'd0;
            r_y0        <= '0;
            r_y1        <= '0;
            r_y2        <= CURVE_RESET;
            r_eta       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_stage     <= n_stage;
            r_y0        <= n_y0;
            r_y1        <= n_y1;
            r_y2        <= n_y2;
            r_eta       <= n_eta;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_t2      <= n_t2;
        r_acc0    <= n_acc0;
        r_acc1    <= n_acc1;
        r_acc2    <= n_acc2;
        r_p       <= n_p;
        r_kq      <= n_kq;
        r_coef    <= n_coef;
        r_prod    <= n_prod;
        r_o_eta   <= n_o_eta;
        r_o_f     <= n_o_f;
        r_o_slope <= n_o_slope;
        r_o_curve <= n_o_curve;
        r_o_done  <= n_o_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= STEP_RESET;
            r_init_curve <= CURVE_RESET;
            r_max_steps  <= MAX_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP_SIZE:  r_step_size  <= i_cfg_data[STEP_W-1:0];
                CFG_INIT_CURVE: r_init_curve <= t_word'(i_cfg_data[DATA_W-1:0]);
                CFG_MAX_STEPS:  r_max_steps  <= i_cfg_data[MAX_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_eta_pos   = r_o_eta;
    assign o_f_value   = r_o_f;
    assign o_f_slope   = r_o_slope;
    assign o_f_curve   = r_o_curve;
    assign o_done_res  = r_o_done;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block ready right after taking a word");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result shown outside the output state");

    a_no_trial_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL) && (r_op == OP_T0 || r_op == OP_T1 || r_op == OP_T2))
        |-> (r_stage != 2'd3))
        else $error("trial point computed in the last RK stage");
`endif

endmodule
